[sv/ffbpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffbpa_pkg
// Shared types and constants of the first-fit block pool allocator.
// ----------------------------------------------------------------------------
package ffbpa_pkg;

   localparam int POOL_BLOCKS_DEF  = 256;
   localparam int BLOCK_BYTES_DEF  = 16;
   localparam int HEADER_BYTES_DEF = 8;

   localparam int REQ_W    = 12;
   localparam int AREA_W   = 8;
   localparam int STATUS_W = 2;
   localparam int REQ_MAX  = (2 ** REQ_W) - 1;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_WALK,
      S_CHK,
      S_WR1,
      S_WR2,
      S_RESP
   } walk_state_type;

   typedef struct packed {
      logic rd_en;
      logic len_we;
      logic nxt_we;
   } mem_ctl_type;

endpackage

[sv/first_fit_block_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_block_pool_allocator_core
// First-fit allocator over a pool of fixed-size blocks with an address-ordered
// free list held in on-chip memory.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An allocate first converts the byte
// count plus header into blocks with a reciprocal multiply, then visits the
// free list one node per read of the list memory, whose read is registered;
// a hit that splits its area writes in S_WR1 and S_WR2, an exact fit in
// S_WR2 only, and the result beat is then loaded. A free walks the list to
// its insertion point and links the area in, or writes nothing when the
// area is already free. The walk gives up after POOL_BLOCKS + 1 nodes. The
// next request is taken once the result beat is loaded, and a result still
// waiting in the output register holds the next one back. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module first_fit_block_pool_allocator_core
   import ffbpa_pkg::*;
#(
   parameter int POOL_BLOCKS  = POOL_BLOCKS_DEF,
   parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [REQ_W-1:0]    req_request_bytes,
   input  logic [AREA_W-1:0]   req_freed_area,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [AREA_W-1:0]   rsp_area_start,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW    = $clog2(POOL_BLOCKS);
   localparam int IDX_W = $clog2(POOL_BLOCKS + 1);
   localparam int SUM_W = $clog2(REQ_MAX + HEADER_BYTES + BLOCK_BYTES);

   logic             div_start;
   logic [SUM_W-1:0] div_dividend;
   logic             div_done;
   logic [SUM_W-1:0] div_quotient;
   mem_ctl_type      mem_ctl;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    len_waddr;
   logic [IDX_W-1:0] len_wdata;
   logic [AW-1:0]    nxt_waddr;
   logic [IDX_W-1:0] nxt_wdata;
   logic [IDX_W-1:0] rd_len;
   logic [IDX_W-1:0] rd_nxt;

   ffbpa_div #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .SUM_W       (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ffbpa_store #(
      .POOL_BLOCKS (POOL_BLOCKS),
      .AW          (AW),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mem_ctl),
      .rd_addr   (rd_addr),
      .len_waddr (len_waddr),
      .len_wdata (len_wdata),
      .nxt_waddr (nxt_waddr),
      .nxt_wdata (nxt_wdata),
      .rd_len    (rd_len),
      .rd_nxt    (rd_nxt)
   );

   ffbpa_walk #(
      .POOL_BLOCKS  (POOL_BLOCKS),
      .BLOCK_BYTES  (BLOCK_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .SUM_W        (SUM_W),
      .AW           (AW),
      .IDX_W        (IDX_W)
   ) u_walk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_request_bytes (req_request_bytes),
      .req_freed_area    (req_freed_area),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_area_start    (rsp_area_start),
      .rsp_status        (rsp_status),
      .div_start         (div_start),
      .div_dividend      (div_dividend),
      .div_done          (div_done),
      .div_quotient      (div_quotient),
      .mem_ctl           (mem_ctl),
      .rd_addr           (rd_addr),
      .len_waddr         (len_waddr),
      .len_wdata         (len_wdata),
      .nxt_waddr         (nxt_waddr),
      .nxt_wdata         (nxt_wdata),
      .rd_len            (rd_len),
      .rd_nxt            (rd_nxt)
   );

endmodule

[sv/ffbpa_div.sv]
// ----------------------------------------------------------------------------
// ffbpa_div
// Division by the constant block size through a reciprocal multiply; the
// quotient and done are registered in the cycle after start.
// ----------------------------------------------------------------------------
module ffbpa_div
   import ffbpa_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   parameter int SUM_W       = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   // ceil(2^SH / BLOCK_BYTES) gives the exact floor for any SUM_W-bit dividend
   localparam int SH  = SUM_W + $clog2(BLOCK_BYTES);
   localparam int M_W = SUM_W + 1;
   localparam int P_W = SUM_W + M_W;
   localparam logic [63:0]    ONE_SH  = 64'd1 << SH;
   localparam logic [M_W-1:0] RECIP_C =
      M_W'((ONE_SH + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

   logic             done_ff, done_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [P_W-1:0]   prod;

   always_comb begin
      prod    = P_W'(dividend) * P_W'(RECIP_C);
      done_in = start;
      quo_in  = start ? SUM_W'(prod >> SH) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/ffbpa_store.sv]
// ----------------------------------------------------------------------------
// ffbpa_store
// Area length and next-link memories, one read and one write port each,
// registered read. Entry 0 reads as the whole pool until first written.
// ----------------------------------------------------------------------------
module ffbpa_store
   import ffbpa_pkg::*;
#(
   parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
   parameter int AW          = $clog2(POOL_BLOCKS),
   parameter int IDX_W       = $clog2(POOL_BLOCKS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  mem_ctl_type      ctl,
   input  logic [AW-1:0]    rd_addr,
   input  logic [AW-1:0]    len_waddr,
   input  logic [IDX_W-1:0] len_wdata,
   input  logic [AW-1:0]    nxt_waddr,
   input  logic [IDX_W-1:0] nxt_wdata,
   output logic [IDX_W-1:0] rd_len,
   output logic [IDX_W-1:0] rd_nxt
);

   localparam logic [IDX_W-1:0] END_C = IDX_W'(POOL_BLOCKS);

   logic [IDX_W-1:0] len_mem [POOL_BLOCKS];
   logic [IDX_W-1:0] nxt_mem [POOL_BLOCKS];

   logic [IDX_W-1:0] len_q_ff, nxt_q_ff;
   logic             len0_fresh_ff, len0_fresh_in;
   logic             nxt0_fresh_ff, nxt0_fresh_in;
   logic             len_hit_ff, len_hit_in;
   logic             nxt_hit_ff, nxt_hit_in;

   always_comb begin
      len0_fresh_in = len0_fresh_ff && !(ctl.len_we && (len_waddr == '0));
      nxt0_fresh_in = nxt0_fresh_ff && !(ctl.nxt_we && (nxt_waddr == '0));
      len_hit_in    = ctl.rd_en ? (len0_fresh_ff && (rd_addr == '0)) : len_hit_ff;
      nxt_hit_in    = ctl.rd_en ? (nxt0_fresh_ff && (rd_addr == '0)) : nxt_hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len0_fresh_ff <= 1'b1;
         nxt0_fresh_ff <= 1'b1;
         len_hit_ff    <= 1'b0;
         nxt_hit_ff    <= 1'b0;
      end else begin
         len0_fresh_ff <= len0_fresh_in;
         nxt0_fresh_ff <= nxt0_fresh_in;
         len_hit_ff    <= len_hit_in;
         nxt_hit_ff    <= nxt_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (ctl.rd_en) begin
         len_q_ff <= len_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.nxt_we) begin
         nxt_mem[nxt_waddr] <= nxt_wdata;
      end
      if (ctl.rd_en) begin
         nxt_q_ff <= nxt_mem[rd_addr];
      end
   end

   assign rd_len = len_hit_ff ? END_C : len_q_ff;
   assign rd_nxt = nxt_hit_ff ? END_C : nxt_q_ff;

endmodule

[sv/ffbpa_walk.sv]
// ----------------------------------------------------------------------------
// ffbpa_walk
// Request sequencer: walks the free list one node per read, then splits,
// unlinks or inserts, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module ffbpa_walk
   import ffbpa_pkg::*;
#(
   parameter int POOL_BLOCKS  = POOL_BLOCKS_DEF,
   parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int SUM_W        = 14,
   parameter int AW           = $clog2(POOL_BLOCKS),
   parameter int IDX_W        = $clog2(POOL_BLOCKS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [REQ_W-1:0]    req_request_bytes,
   input  logic [AREA_W-1:0]   req_freed_area,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [AREA_W-1:0]   rsp_area_start,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                div_start,
   output logic [SUM_W-1:0]    div_dividend,
   input  logic                div_done,
   input  logic [SUM_W-1:0]    div_quotient,
   output mem_ctl_type         mem_ctl,
   output logic [AW-1:0]       rd_addr,
   output logic [AW-1:0]       len_waddr,
   output logic [IDX_W-1:0]    len_wdata,
   output logic [AW-1:0]       nxt_waddr,
   output logic [IDX_W-1:0]    nxt_wdata,
   input  logic [IDX_W-1:0]    rd_len,
   input  logic [IDX_W-1:0]    rd_nxt
);

   localparam int CMP_W = ((IDX_W > SUM_W) ? IDX_W : SUM_W) + 1;
   localparam int ST_W  = $clog2(POOL_BLOCKS + 2);
   localparam logic [IDX_W-1:0] END_C = IDX_W'(POOL_BLOCKS);
   localparam logic [ST_W-1:0]  STEP_LIM = ST_W'(POOL_BLOCKS);
   localparam logic [SUM_W-1:0] ADD_C = SUM_W'(HEADER_BYTES + BLOCK_BYTES - 1);

   walk_state_type state_ff, state_in;

   logic                act_ff, act_in;
   logic [AREA_W-1:0]   area_ff, area_in;
   logic [SUM_W-1:0]    need_ff, need_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    prev_ff, prev_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [ST_W-1:0]     steps_ff, steps_in;
   logic [IDX_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    aft_ff, aft_in;
   logic                split_ff, split_in;
   logic [AREA_W-1:0]   res_start_ff, res_start_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic             accept;
   logic             in_pool;
   logic             walk_more;
   logic             hit_area;
   logic             fit;
   logic             split_now;
   logic             slot_free;
   logic [CMP_W-1:0] area_w, cur_w, need_w, rem_w;
   logic [IDX_W-1:0] area_idx, rem_idx, link_now, target;

   // status and helper terms
   always_comb begin
      accept    = req_valid && (state_ff == S_IDLE);
      area_w    = CMP_W'(area_ff);
      area_idx  = area_w[IDX_W-1:0];
      cur_w     = CMP_W'(cur_ff);
      need_w    = CMP_W'(need_ff);
      rem_w     = cur_w + need_w;
      rem_idx   = rem_w[IDX_W-1:0];
      in_pool   = (CMP_W'(req_freed_area) < CMP_W'(END_C));
      if (act_ff == ACT_ALLOC) begin
         walk_more = (cur_ff < END_C) && (steps_ff <= STEP_LIM);
      end else begin
         walk_more = (cur_w < area_w) && (steps_ff <= STEP_LIM);
      end
      hit_area  = (cur_w == area_w);
      link_now  = (rd_nxt > END_C) ? END_C : rd_nxt;
      fit       = (CMP_W'(rd_len) >= need_w);
      split_now = (CMP_W'(rd_len) != need_w) && (rem_w < CMP_W'(END_C));
      slot_free = !rsp_valid_ff || rsp_ready;
      if (act_ff == ACT_FREE) begin
         target = area_idx;
      end else if (split_ff) begin
         target = rem_idx;
      end else begin
         target = aft_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_ALLOC) begin
                  state_in = S_DIV;
               end else if (in_pool) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_more) begin
               state_in = S_CHK;
            end else if (act_ff == ACT_ALLOC) begin
               state_in = S_RESP;
            end else if (hit_area) begin
               state_in = S_RESP;
            end else begin
               state_in = S_WR1;
            end
         end
         S_CHK: begin
            if ((act_ff == ACT_ALLOC) && fit) begin
               state_in = split_now ? S_WR1 : S_WR2;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WR1: state_in = S_WR2;
         S_WR2: state_in = S_RESP;
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      div_start     = accept && (req_action == ACT_ALLOC);
      div_dividend  = SUM_W'(req_request_bytes) + ADD_C;
      mem_ctl       = '0;
      rd_addr       = cur_ff[AW-1:0];
      len_waddr     = rem_idx[AW-1:0];
      len_wdata     = len_ff - need_w[IDX_W-1:0];
      nxt_waddr     = rem_idx[AW-1:0];
      nxt_wdata     = aft_ff;
      act_in        = act_ff;
      area_in       = area_ff;
      need_in       = need_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      steps_in      = steps_ff;
      len_in        = len_ff;
      aft_in        = aft_ff;
      split_in      = split_ff;
      res_start_in  = res_start_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in        = req_action;
               area_in       = req_freed_area;
               cur_in        = head_ff;
               prev_in       = END_C;
               steps_in      = '0;
               split_in      = 1'b0;
               res_start_in  = '0;
               res_status_in = (req_action == ACT_ALLOC) ? ST_NO_FIT : ST_FREED;
            end
         end
         S_DIV: begin
            need_in = div_quotient;
         end
         S_WALK: begin
            mem_ctl.rd_en = walk_more;
         end
         S_CHK: begin
            len_in   = rd_len;
            aft_in   = link_now;
            split_in = split_now;
            if ((act_ff == ACT_ALLOC) && fit) begin
               res_start_in  = cur_w[AREA_W-1:0];
               res_status_in = ST_ALLOCATED;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_now;
               steps_in = steps_ff + ST_W'(1);
            end
         end
         S_WR1: begin
            if (act_ff == ACT_ALLOC) begin
               mem_ctl.len_we = 1'b1;
               mem_ctl.nxt_we = 1'b1;
            end else begin
               mem_ctl.nxt_we = 1'b1;
               nxt_waddr      = area_idx[AW-1:0];
               nxt_wdata      = (cur_ff < END_C) ? cur_ff : END_C;
            end
         end
         S_WR2: begin
            if ((act_ff == ACT_ALLOC) && split_ff) begin
               mem_ctl.len_we = 1'b1;
               len_waddr      = cur_ff[AW-1:0];
               len_wdata      = need_w[IDX_W-1:0];
            end
            nxt_waddr = prev_ff[AW-1:0];
            nxt_wdata = target;
            if (prev_ff >= END_C) begin
               head_in = target;
            end else begin
               mem_ctl.nxt_we = 1'b1;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = res_start_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      area_ff       <= area_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      len_ff        <= len_in;
      aft_ff        <= aft_in;
      split_ff      <= split_in;
      res_start_ff  <= res_start_in;
      res_status_ff <= res_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_area_start = rsp_start_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[verif/first_fit_block_pool_allocator_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_pool_allocator_core_test
// Self-checking bench for the first-fit block pool allocator. A short table of
// directed beats covers the full pool, an empty list, oversize requests, a
// double free and exact and split fits. Random allocate and free traffic
// follows. Replies are checked against typed-in rows or an in-bench free list.
// Both channels stall in random bursts, with calm stretches in between.
// ----------------------------------------------------------------------------
module first_fit_block_pool_allocator_core_test;
   import ffbpa_pkg::*;

   localparam int NBLK        = POOL_BLOCKS_DEF;
   localparam int LIST_END    = POOL_BLOCKS_DEF;
   localparam int RAND_OPS    = 700;
   localparam int CALM_TAIL   = 60;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [AREA_W-1:0]   area_start;
      logic [STATUS_W-1:0] status;
   } reply_type;

   typedef struct packed {
      logic              action;
      logic [REQ_W-1:0]  bytes;
      logic [AREA_W-1:0] area;
      bit                typed;
      reply_type         reply;
   } plan_row_type;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_action        = ACT_ALLOC;
   logic [REQ_W-1:0]    req_request_bytes = '0;
   logic [AREA_W-1:0]   req_freed_area    = '0;
   logic                rsp_ready         = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [AREA_W-1:0]   rsp_area_start;
   logic [STATUS_W-1:0] rsp_status;

   // free-list shadow
   logic [8:0] pool_len  [NBLK];
   logic [8:0] pool_next [NBLK];
   int unsigned pool_head;
   bit         len_known [NBLK];
   int unsigned known_areas [$];
   int unsigned live_areas  [$];

   reply_type pending_replies [$];
   int        mismatch_count = 0;
   int        cycle_count    = 0;
   int        idle_level     = 2;

   // directed beats: expected reply typed in only where it is obvious
   plan_row_type plan [20] = '{
      '{ACT_ALLOC, 12'd4088, 8'hFF, 1'b1, '{8'd0, ST_ALLOCATED}},  // whole pool
      '{ACT_ALLOC, 12'd0,    8'h00, 1'b1, '{8'd0, ST_NO_FIT}},     // empty list
      '{ACT_FREE,  12'd4095, 8'h00, 1'b1, '{8'd0, ST_FREED}},
      '{ACT_ALLOC, 12'd4095, 8'h80, 1'b1, '{8'd0, ST_NO_FIT}},     // beyond pool
      '{ACT_ALLOC, 12'd0,    8'h00, 1'b1, '{8'd0, ST_ALLOCATED}},
      '{ACT_ALLOC, 12'd7,    8'h00, 1'b0, '{8'd0, ST_ALLOCATED}},
      '{ACT_ALLOC, 12'd24,   8'h00, 1'b0, '{8'd0, ST_ALLOCATED}},
      '{ACT_ALLOC, 12'd100,  8'h00, 1'b0, '{8'd0, ST_ALLOCATED}},
      '{ACT_FREE,  12'd0,    8'h02, 1'b1, '{8'd0, ST_FREED}},
      '{ACT_FREE,  12'd0,    8'h02, 1'b1, '{8'd0, ST_FREED}},      // double free
      '{ACT_ALLOC, 12'd24,   8'h00, 1'b0, '{8'd0, ST_ALLOCATED}},  // exact fit
      '{ACT_FREE,  12'd0,    8'h00, 1'b1, '{8'd0, ST_FREED}},
      '{ACT_FREE,  12'd0,    8'h04, 1'b1, '{8'd0, ST_FREED}},
      '{ACT_FREE,  12'd0,    8'h01, 1'b1, '{8'd0, ST_FREED}},      // insert mid-list
      '{ACT_ALLOC, 12'd90,   8'h00, 1'b0, '{8'd0, ST_ALLOCATED}},
      '{ACT_ALLOC, 12'd4088, 8'h00, 1'b1, '{8'd0, ST_NO_FIT}},
      '{ACT_ALLOC, 12'd4072, 8'h00, 1'b1, '{8'd0, ST_NO_FIT}},
      '{ACT_ALLOC, 12'd3912, 8'h00, 1'b0, '{8'd0, ST_ALLOCATED}},
      '{ACT_FREE,  12'd0,    8'h0B, 1'b1, '{8'd0, ST_FREED}},
      '{ACT_ALLOC, 12'd2000, 8'h00, 1'b0, '{8'd0, ST_ALLOCATED}}
   };

   first_fit_block_pool_allocator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_request_bytes (req_request_bytes),
      .req_freed_area    (req_freed_area),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_area_start    (rsp_area_start),
      .rsp_status        (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int unsigned link_after(int unsigned node);
      if (node >= LIST_END)
         return LIST_END;
      return (pool_next[node] > LIST_END) ? LIST_END : 32'(pool_next[node]);
   endfunction

   // prev == LIST_END stands for the head pointer
   function automatic void relink(int unsigned prev, int unsigned target);
      if (prev >= LIST_END)
         pool_head = target;
      else
         pool_next[prev] = target[8:0];
   endfunction

   function automatic reply_type pool_update(logic act, logic [REQ_W-1:0] bytes,
                                             logic [AREA_W-1:0] area);
      reply_type   res;
      int unsigned need, prev, cur, steps, len, after, rem;
      res.area_start = '0;
      prev  = LIST_END;
      cur   = pool_head;
      steps = 0;
      if (act == ACT_ALLOC) begin
         res.status = ST_NO_FIT;
         need = (int'(bytes) + HEADER_BYTES_DEF + BLOCK_BYTES_DEF - 1) / BLOCK_BYTES_DEF;
         while (cur < LIST_END && steps <= NBLK) begin
            len = 32'(pool_len[cur]);
            if (len >= need) begin
               after = link_after(cur);
               rem   = cur + need;
               if (len == need || rem >= LIST_END) begin
                  relink(prev, after);
               end else begin
                  pool_len[rem]  = 9'(len - need);
                  pool_next[rem] = after[8:0];
                  pool_len[cur]  = need[8:0];
                  if (!len_known[rem]) begin
                     len_known[rem] = 1'b1;
                     known_areas.push_back(rem);
                  end
                  relink(prev, rem);
               end
               res.area_start = cur[AREA_W-1:0];
               res.status     = ST_ALLOCATED;
               live_areas.push_back(cur);
               break;
            end
            prev = cur;
            cur  = link_after(cur);
            steps++;
         end
      end else begin
         res.status = ST_FREED;
         for (int k = live_areas.size() - 1; k >= 0; k--)
            if (live_areas[k] == area)
               live_areas.delete(k);
         if (area < LIST_END) begin
            while (cur < area && steps <= NBLK) begin
               prev = cur;
               cur  = link_after(cur);
               steps++;
            end
            if (cur != area) begin
               pool_next[area] = (cur < LIST_END) ? cur[8:0] : 9'(LIST_END);
               relink(prev, area);
            end
         end
      end
      return res;
   endfunction

   task automatic offer_beat(input logic act, input logic [REQ_W-1:0] bytes,
                             input logic [AREA_W-1:0] area);
      req_valid         <= 1'b1;
      req_action        <= act;
      req_request_bytes <= bytes;
      req_freed_area    <= area;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_pause();
      int gap;
      if ((idle_level == 2 && $urandom_range(0, 3) == 0) ||
          (idle_level == 1 && $urandom_range(0, 15) == 0)) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // reply side: random stall bursts, check each accepted beat
   initial begin
      int        stall_left;
      reply_type want;
      stall_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               $display("%0t unexpected reply: area_start %0d status %0d",
                        $time, rsp_area_start, rsp_status);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_area_start !== want.area_start) begin
                  $display("%0t area_start mismatch: expected %0d actual %0d",
                           $time, want.area_start, rsp_area_start);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ((idle_level == 2 && $urandom_range(0, 4) == 0) ||
                      (idle_level == 1 && $urandom_range(0, 19) == 0)) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reply_type         want;
      logic              act;
      logic [REQ_W-1:0]  bytes;
      logic [AREA_W-1:0] area;
      int                roll;

      foreach (pool_len[i]) begin
         pool_len[i]  = '0;
         pool_next[i] = '0;
         len_known[i] = 1'b0;
      end
      pool_len[0]  = 9'(NBLK);
      pool_next[0] = 9'(LIST_END);
      pool_head    = 0;
      len_known[0] = 1'b1;
      known_areas.push_back(0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         offer_beat(plan[i].action, plan[i].bytes, plan[i].area);
         want = pool_update(plan[i].action, plan[i].bytes, plan[i].area);
         pending_replies.push_back(plan[i].typed ? plan[i].reply : want);
         sender_pause();
      end

      for (int n = 0; n < RAND_OPS; n++) begin
         if (n >= RAND_OPS - CALM_TAIL)
            idle_level = 0;
         else
            idle_level = 2 - (n / 64) % 3;
         if (n == RAND_OPS / 2) begin
            // hold off until every reply is back
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_replies.size() != 0);
         end
         roll = $urandom_range(0, 99);
         if (live_areas.size() == 0 || $urandom_range(0, 99) < 55) begin
            act  = ACT_ALLOC;
            area = AREA_W'($urandom);
            if (roll < 70)
               bytes = REQ_W'($urandom_range(0, 120));
            else if (roll < 92)
               bytes = REQ_W'($urandom_range(0, 1200));
            else
               bytes = REQ_W'($urandom_range(0, REQ_MAX));
         end else begin
            act   = ACT_FREE;
            bytes = REQ_W'($urandom);
            if (roll < 85)
               area = AREA_W'(live_areas[$urandom_range(0, live_areas.size() - 1)]);
            else
               area = AREA_W'(known_areas[$urandom_range(0, known_areas.size() - 1)]);
         end
         offer_beat(act, bytes, area);
         pending_replies.push_back(pool_update(act, bytes, area));
         sender_pause();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
